// ----- hdl/kpe_pkg.sv -----
`timescale 1ns / 1ps

package kpe_pkg;

    localparam int NUM_KEYS     = 16;
    localparam int NUM_BUTTONS  = 3;
    localparam int NUM_ENCODERS = 3;

    localparam int KEY_W = 16;
    localparam int BTN_W = 3;
    localparam int ENC_W = 6;

    localparam int NUM_SLOTS = NUM_ENCODERS + NUM_BUTTONS + NUM_KEYS;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] EV_MAKE  = 8'h10;
    localparam logic [7:0] EV_BREAK = 8'h20;
    localparam logic [7:0] EV_LEFT  = 8'h04;
    localparam logic [7:0] EV_RIGHT = 8'h08;
    localparam logic [7:0] SRC_KEY  = 8'h00;
    localparam logic [7:0] SRC_ENC  = 8'h40;
    localparam logic [7:0] SRC_BTN  = 8'h80;

    localparam logic [3:0] KEY_CODE [0:15] = '{
        4'd1, 4'd4, 4'd7, 4'd10, 4'd2, 4'd5, 4'd8, 4'd0,
        4'd3, 4'd6, 4'd9, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
    };

    // For encoder slots the level bit means right; for buttons and keys it is
    // the new pin level, where one means released.
    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic [NUM_SLOTS-1:0] level;
    } kpe_job_t;

    function automatic logic [7:0] slot_code(input logic [SLOT_W-1:0] idx,
                                             input logic level);
        logic [SLOT_W-1:0] rel;
        logic [7:0]        code;
        if (idx < SLOT_W'(NUM_ENCODERS)) begin
            rel  = idx;
            code = SRC_ENC | EV_MAKE | (level ? EV_RIGHT : EV_LEFT) | 8'(rel);
        end else if (idx < SLOT_W'(NUM_ENCODERS + NUM_BUTTONS)) begin
            rel  = idx - SLOT_W'(NUM_ENCODERS);
            code = SRC_BTN | (level ? EV_BREAK : EV_MAKE) | 8'(rel);
        end else begin
            rel  = idx - SLOT_W'(NUM_ENCODERS + NUM_BUTTONS);
            code = SRC_KEY | (level ? EV_BREAK : EV_MAKE) | 8'(KEY_CODE[rel[3:0]]);
        end
        return code;
    endfunction

endpackage

// ----- hdl/kpe_front.sv -----
`timescale 1ns / 1ps

module kpe_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [kpe_pkg::KEY_W-1:0] s_key_matrix,
    input  logic [kpe_pkg::BTN_W-1:0] s_button_pins,
    input  logic [kpe_pkg::ENC_W-1:0] s_encoder_pins,
    input  logic                     fifo_full,
    output logic                     push_valid,
    output kpe_pkg::kpe_job_t        push_job
);
    import kpe_pkg::*;

    logic [NUM_KEYS-1:0]    prev_keys_reg, prev_keys_next;
    logic [NUM_BUTTONS-1:0] prev_btns_reg, prev_btns_next;
    logic [1:0]             prev_enc_reg  [NUM_ENCODERS];
    logic [1:0]             prev_enc_next [NUM_ENCODERS];
    logic                   accept;
    kpe_job_t               job;

    assign s_ready = !fifo_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        logic [1:0] pair;
        logic [1:0] diff;
        job = '0;
        for (int n = 0; n < NUM_ENCODERS; n++) begin
            pair = s_encoder_pins[2*n +: 2];
            diff = pair ^ prev_enc_reg[n];
            job.mask[n]  = (pair[0] == pair[1]) && (diff == 2'b01 || diff == 2'b10);
            job.level[n] = (diff == 2'b10);
            prev_enc_next[n] = accept ? pair : prev_enc_reg[n];
        end
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            job.mask[NUM_ENCODERS + b]  = s_button_pins[b] ^ prev_btns_reg[b];
            job.level[NUM_ENCODERS + b] = s_button_pins[b];
            prev_btns_next[b] = accept ? s_button_pins[b] : prev_btns_reg[b];
        end
        for (int k = 0; k < NUM_KEYS; k++) begin
            job.mask[NUM_ENCODERS + NUM_BUTTONS + k]  = s_key_matrix[k] ^ prev_keys_reg[k];
            job.level[NUM_ENCODERS + NUM_BUTTONS + k] = s_key_matrix[k];
            prev_keys_next[k] = accept ? s_key_matrix[k] : prev_keys_reg[k];
        end
    end

    assign push_valid = accept && (job.mask != '0);
    assign push_job   = job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_keys_reg <= '1;
            prev_btns_reg <= '1;
            for (int n = 0; n < NUM_ENCODERS; n++) begin
                prev_enc_reg[n] <= '0;
            end
        end else begin
            prev_keys_reg <= prev_keys_next;
            prev_btns_reg <= prev_btns_next;
            for (int n = 0; n < NUM_ENCODERS; n++) begin
                prev_enc_reg[n] <= prev_enc_next[n];
            end
        end
    end

`ifndef ASSERT_OFF
    a_keys_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> prev_keys_reg == $past(s_key_matrix[NUM_KEYS-1:0]))
        else $error("stored key sample does not follow accepted item");
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_full |-> !push_valid)
        else $error("job pushed into a full queue");
`endif

endmodule

// ----- hdl/kpe_fifo.sv -----
`timescale 1ns / 1ps

module kpe_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    input  kpe_pkg::kpe_job_t push_job,
    output logic              full,
    output logic              pop_valid,
    input  logic              pop_ready,
    output kpe_pkg::kpe_job_t pop_job
);
    import kpe_pkg::*;

    kpe_job_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full      = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_job   = mem_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + FIFO_CNT_W'(do_push) - FIFO_CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue count exceeds depth");
    a_job_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_valid |-> pop_job.mask != '0)
        else $error("queue holds a job without events");
`endif

endmodule

// ----- hdl/kpe_back.sv -----
`timescale 1ns / 1ps

module kpe_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  kpe_pkg::kpe_job_t pop_job,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_event_code,
    output logic              m_last_event
);
    import kpe_pkg::*;

    logic [NUM_SLOTS-1:0] mask_reg, mask_next;
    logic [NUM_SLOTS-1:0] level_reg, level_next;
    logic                 m_valid_reg, m_valid_next;
    logic [7:0]           code_reg, code_next;
    logic                 last_reg, last_next;
    logic [SLOT_W-1:0]    idx;
    logic [NUM_SLOTS-1:0] rest;
    logic                 emit;

    always_comb begin
        idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                idx = SLOT_W'(i);
            end
        end
    end

    assign rest      = mask_reg & (mask_reg - 1'b1);
    assign emit      = (mask_reg != '0) && (!m_valid_reg || m_ready);
    assign pop_ready = (mask_reg == '0);

    always_comb begin
        mask_next    = mask_reg;
        level_next   = level_reg;
        m_valid_next = m_valid_reg;
        code_next    = code_reg;
        last_next    = last_reg;
        if (pop_ready && pop_valid) begin
            mask_next  = pop_job.mask;
            level_next = pop_job.level;
        end else if (emit) begin
            mask_next = rest;
        end
        if (emit) begin
            m_valid_next = 1'b1;
            code_next    = slot_code(idx, level_reg[idx]);
            last_next    = (rest == '0);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            mask_reg    <= mask_next;
            m_valid_reg <= m_valid_next;
        end
        level_reg <= level_next;
        code_reg  <= code_next;
        last_reg  <= last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_event_code = code_reg;
    assign m_last_event = last_reg;

`ifndef ASSERT_OFF
    a_last_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && rest == '0) |=> m_valid && m_last_event)
        else $error("final item not marked last");
    a_not_last_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && rest != '0) |=> mask_reg != '0 && !m_last_event)
        else $error("job ended before its last item");
`endif

endmodule

// ----- hdl/keypad_encoder_event_generator_core.sv -----
`timescale 1ns / 1ps

// Key matrix, push-button and quadrature encoder event generator.
// The s_ channel takes one scan tick per item: a 16-key snapshot, three
// button pins and three encoder pin pairs, all compared with the samples of
// the previous tick. The m_ channel delivers one event byte per item, in the
// order encoders, buttons, keys, with m_last_event set on the final event of
// a tick. A tick with no change produces no item.
// The front end classifies a tick in the cycle it is accepted and places the
// changes in a two-entry job queue; s_ready is low only while that queue is
// full. The back end turns a job into events at one per cycle unless the
// receiver stalls, and loads a job only after the last one is drained; the first
// event of a tick passes the queue entry, the mask register and the output register.
// A stalled receiver holds the current event in the output register; the
// queue keeps taking ticks until both entries are occupied.
// Reset is synchronous and active low. It empties the queue and the output
// register, sets the stored key and button samples to released and clears
// the stored encoder pairs.
module keypad_encoder_event_generator_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [kpe_pkg::KEY_W-1:0] s_key_matrix,
    input  logic [kpe_pkg::BTN_W-1:0] s_button_pins,
    input  logic [kpe_pkg::ENC_W-1:0] s_encoder_pins,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_event_code,
    output logic                      m_last_event
);
    import kpe_pkg::*;

    logic     fifo_full;
    logic     push_valid;
    kpe_job_t push_job;
    logic     pop_valid;
    logic     pop_ready;
    kpe_job_t pop_job;

    kpe_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_key_matrix   (s_key_matrix),
        .s_button_pins  (s_button_pins),
        .s_encoder_pins (s_encoder_pins),
        .fifo_full      (fifo_full),
        .push_valid     (push_valid),
        .push_job       (push_job)
    );

    kpe_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .full       (fifo_full),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    kpe_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_job      (pop_job),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_code (m_event_code),
        .m_last_event (m_last_event)
    );

endmodule
